@@ rtl/pva_pkg.sv @@
// ----------------------------------------------------------------------------
// pva_pkg
// Shared codes, field widths and types of the voice allocator.
// ----------------------------------------------------------------------------
package pva_pkg;

  localparam int CH_W   = 4;
  localparam int NOTE_W = 7;
  localparam int VEL_W  = 7;
  localparam int ACT_W  = 3;
  localparam int MAXV_W = 6;
  localparam int OP_W   = 2;

  localparam logic [OP_W-1:0] OP_NOTE   = 2'd0;
  localparam logic [OP_W-1:0] OP_STEAL  = 2'd1;
  localparam logic [OP_W-1:0] OP_FINISH = 2'd2;
  localparam logic [OP_W-1:0] OP_RSVD   = 2'd3;

  localparam logic [ACT_W-1:0] ACT_START    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_STEAL    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_RELEASE  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_NO_MATCH = 3'd3;
  localparam logic [ACT_W-1:0] ACT_REMOVED  = 3'd4;
  localparam logic [ACT_W-1:0] ACT_FULL     = 3'd5;

  localparam logic REG_MAX_VOICES = 1'b0;
  localparam logic REG_FORCED     = 1'b1;

  typedef struct packed {
    logic live;
    logic note_hit;
    logic tag_hit;
  } cmp_t;

endpackage

@@ rtl/pva_cmp.sv @@
// ----------------------------------------------------------------------------
// pva_cmp
// Shared compare unit: checks one voice entry against the current key.
// ----------------------------------------------------------------------------
module pva_cmp import pva_pkg::*; #(
  parameter int TAG_BITS = 16
) (
  input  logic [TAG_BITS-1:0] tag_i,
  input  logic [CH_W-1:0]     ch_i,
  input  logic [NOTE_W-1:0]   note_i,
  input  logic                steal_i,
  input  logic [TAG_BITS-1:0] key_tag_i,
  input  logic [CH_W-1:0]     key_ch_i,
  input  logic [NOTE_W-1:0]   key_note_i,
  output cmp_t                res_o
);

  assign res_o.live     = !steal_i;
  assign res_o.note_hit = !steal_i && (ch_i == key_ch_i) && (note_i == key_note_i);
  assign res_o.tag_hit  = (tag_i == key_tag_i);

endmodule

@@ rtl/pva_seq.sv @@
// ----------------------------------------------------------------------------
// pva_seq
// Sequencer: voice list memory, scan and compaction passes, result register.
// ----------------------------------------------------------------------------
module pva_seq import pva_pkg::*; #(
  parameter int CAPACITY = 32,
  parameter int TAG_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [OP_W-1:0]     operation_i,
  input  logic [CH_W-1:0]     midi_channel_i,
  input  logic [NOTE_W-1:0]   midi_note_i,
  input  logic [VEL_W-1:0]    velocity_i,
  input  logic                force_req_i,
  input  logic                steal_all_i,
  input  logic [TAG_BITS-1:0] finished_tag_i,
  input  logic [MAXV_W-1:0]   max_voices_i,
  input  logic                forced_steal_i,
  output logic                busy_o,
  output logic                valid_o,
  output logic [ACT_W-1:0]    action_o,
  output logic [TAG_BITS-1:0] voice_tag_o,
  output logic [CH_W-1:0]     out_channel_o,
  output logic [NOTE_W-1:0]   out_note_o,
  output logic [VEL_W-1:0]    out_velocity_o,
  output logic                forced_o,
  output logic                last_o
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = TAG_BITS + CH_W + NOTE_W + 1;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_APPEND, ST_SHIFT} state_e;
  typedef enum logic [1:0] {K_ON, K_OFF, K_STEAL, K_FIN} kind_e;

  typedef struct packed {
    logic [ACT_W-1:0]    act;
    logic [TAG_BITS-1:0] tag;
    logic [CH_W-1:0]     ch;
    logic [NOTE_W-1:0]   note;
    logic [VEL_W-1:0]    vel;
    logic                forced;
    logic                last;
  } res_t;

  state_e state_q, state_d;
  kind_e  kind_q, kind_d;

  logic [CH_W-1:0]     ch_q, ch_d;
  logic [NOTE_W-1:0]   note_q, note_d;
  logic [VEL_W-1:0]    vel_q, vel_d;
  logic                freq_q, freq_d;
  logic                all_q, all_d;
  logic [TAG_BITS-1:0] ftag_q, ftag_d;

  logic [CW-1:0]       n_q, n_d;
  logic [TAG_BITS-1:0] next_tag_q, next_tag_d;
  logic [CW-1:0]       ptr_q, ptr_d;
  logic                pv_q, pv_d;
  logic [IW-1:0]       pidx_q, pidx_d;
  logic                stop_q, stop_d;
  logic [CW-1:0]       live_q, live_d;
  logic                found_q, found_d;
  logic [IW-1:0]       hit_idx_q, hit_idx_d;
  logic [TAG_BITS-1:0] hit_tag_q, hit_tag_d;
  logic [CH_W-1:0]     hit_ch_q, hit_ch_d;
  logic [NOTE_W-1:0]   hit_note_q, hit_note_d;
  logic                pend_q, pend_d;
  logic [TAG_BITS-1:0] pend_tag_q, pend_tag_d;

  logic                valid_q, valid_d;
  res_t                res_q, res_d;

  logic [EW-1:0]       mem_q [CAPACITY];
  logic [EW-1:0]       rdata_q;
  logic [IW-1:0]       raddr;
  logic                we;
  logic [IW-1:0]       waddr;
  logic [EW-1:0]       wdata;

  logic [TAG_BITS-1:0] e_tag;
  logic [CH_W-1:0]     e_ch;
  logic [NOTE_W-1:0]   e_note;
  logic                e_steal;
  cmp_t                cmp;
  logic                issue;
  logic                scan_done;
  logic                steal_now;

  assign e_tag   = rdata_q[EW-1 -: TAG_BITS];
  assign e_ch    = rdata_q[NOTE_W+CH_W -: CH_W];
  assign e_note  = rdata_q[NOTE_W:1];
  assign e_steal = rdata_q[0];

  pva_cmp #(
    .TAG_BITS(TAG_BITS)
  ) u_cmp (
    .tag_i      (e_tag),
    .ch_i       (e_ch),
    .note_i     (e_note),
    .steal_i    (e_steal),
    .key_tag_i  (ftag_q),
    .key_ch_i   (ch_q),
    .key_note_i (note_q),
    .res_o      (cmp)
  );

  assign raddr     = ptr_q[IW-1:0];
  assign issue     = ((state_q == ST_SCAN && !stop_q) || state_q == ST_SHIFT) && (ptr_q < n_q);
  assign scan_done = !pv_q && (stop_q || ptr_q >= n_q);
  assign steal_now = (max_voices_i != '0) && (8'(live_q) >= 8'(max_voices_i)) && found_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  always_comb begin
    state_d    = state_q;
    kind_d     = kind_q;
    ch_d       = ch_q;
    note_d     = note_q;
    vel_d      = vel_q;
    freq_d     = freq_q;
    all_d      = all_q;
    ftag_d     = ftag_q;
    n_d        = n_q;
    next_tag_d = next_tag_q;
    ptr_d      = issue ? ptr_q + 1'b1 : ptr_q;
    pv_d       = issue;
    pidx_d     = ptr_q[IW-1:0];
    stop_d     = stop_q;
    live_d     = live_q;
    found_d    = found_q;
    hit_idx_d  = hit_idx_q;
    hit_tag_d  = hit_tag_q;
    hit_ch_d   = hit_ch_q;
    hit_note_d = hit_note_q;
    pend_d     = pend_q;
    pend_tag_d = pend_tag_q;
    valid_d    = 1'b0;
    res_d      = res_q;
    we         = 1'b0;
    waddr      = '0;
    wdata      = '0;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          ch_d    = midi_channel_i;
          note_d  = midi_note_i;
          vel_d   = velocity_i;
          freq_d  = force_req_i;
          all_d   = steal_all_i;
          ftag_d  = finished_tag_i;
          ptr_d   = '0;
          stop_d  = 1'b0;
          live_d  = '0;
          found_d = 1'b0;
          pend_d  = 1'b0;
          case (operation_i)
            OP_NOTE: begin
              kind_d  = (velocity_i != '0) ? K_ON : K_OFF;
              state_d = ST_SCAN;
            end
            OP_STEAL: begin
              kind_d  = K_STEAL;
              state_d = ST_SCAN;
            end
            OP_FINISH: begin
              kind_d  = K_FIN;
              state_d = ST_SCAN;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (pv_q) begin
          case (kind_q)
            K_ON: begin
              if (cmp.live) begin
                live_d = live_q + 1'b1;
                if (!found_q) begin
                  found_d    = 1'b1;
                  hit_idx_d  = pidx_q;
                  hit_tag_d  = e_tag;
                  hit_ch_d   = e_ch;
                  hit_note_d = e_note;
                end
              end
            end
            K_OFF: begin
              if (cmp.note_hit) begin
                found_d   = 1'b1;
                hit_tag_d = e_tag;
              end
            end
            K_STEAL: begin
              if (cmp.note_hit && !stop_q) begin
                we    = 1'b1;
                waddr = pidx_q;
                wdata = {rdata_q[EW-1:1], 1'b1};
                if (pend_q) begin
                  valid_d = 1'b1;
                  res_d   = '{act: ACT_STEAL, tag: pend_tag_q, ch: ch_q, note: note_q,
                              vel: '0, forced: freq_q, last: 1'b0};
                end
                pend_d     = 1'b1;
                pend_tag_d = e_tag;
                if (!all_q) begin
                  stop_d = 1'b1;
                end
              end
            end
            default: begin
              if (cmp.tag_hit && !found_q) begin
                found_d   = 1'b1;
                hit_idx_d = pidx_q;
                stop_d    = 1'b1;
                valid_d   = 1'b1;
                res_d     = '{act: ACT_REMOVED, tag: e_tag, ch: e_ch, note: e_note,
                              vel: '0, forced: 1'b0, last: 1'b1};
              end
            end
          endcase
        end else if (scan_done) begin
          case (kind_q)
            K_ON: begin
              if (steal_now) begin
                we      = 1'b1;
                waddr   = hit_idx_q;
                wdata   = {hit_tag_q, hit_ch_q, hit_note_q, 1'b1};
                valid_d = 1'b1;
                res_d   = '{act: ACT_STEAL, tag: hit_tag_q, ch: hit_ch_q, note: hit_note_q,
                            vel: '0, forced: forced_steal_i, last: 1'b0};
              end
              state_d = ST_APPEND;
            end
            K_OFF: begin
              valid_d = 1'b1;
              if (found_q) begin
                res_d = '{act: ACT_RELEASE, tag: hit_tag_q, ch: ch_q, note: note_q,
                          vel: '0, forced: 1'b0, last: 1'b1};
              end else begin
                res_d = '{act: ACT_NO_MATCH, tag: '0, ch: ch_q, note: note_q,
                          vel: '0, forced: 1'b0, last: 1'b1};
              end
              state_d = ST_IDLE;
            end
            K_STEAL: begin
              valid_d = 1'b1;
              if (pend_q) begin
                res_d = '{act: ACT_STEAL, tag: pend_tag_q, ch: ch_q, note: note_q,
                          vel: '0, forced: freq_q, last: 1'b1};
              end else begin
                res_d = '{act: ACT_NO_MATCH, tag: '0, ch: ch_q, note: note_q,
                          vel: '0, forced: 1'b0, last: 1'b1};
              end
              state_d = ST_IDLE;
            end
            default: begin
              if (found_q) begin
                ptr_d   = CW'(hit_idx_q) + 1'b1;
                stop_d  = 1'b0;
                state_d = ST_SHIFT;
              end else begin
                valid_d = 1'b1;
                res_d   = '{act: ACT_NO_MATCH, tag: ftag_q, ch: '0, note: '0,
                            vel: '0, forced: 1'b0, last: 1'b1};
                state_d = ST_IDLE;
              end
            end
          endcase
        end
      end

      ST_APPEND: begin
        valid_d = 1'b1;
        if (n_q >= CW'(CAPACITY)) begin
          res_d = '{act: ACT_FULL, tag: '0, ch: ch_q, note: note_q,
                    vel: vel_q, forced: 1'b0, last: 1'b1};
        end else begin
          we         = 1'b1;
          waddr      = n_q[IW-1:0];
          wdata      = {next_tag_q, ch_q, note_q, 1'b0};
          n_d        = n_q + 1'b1;
          next_tag_d = next_tag_q + 1'b1;
          res_d      = '{act: ACT_START, tag: next_tag_q, ch: ch_q, note: note_q,
                         vel: vel_q, forced: 1'b0, last: 1'b1};
        end
        state_d = ST_IDLE;
      end

      ST_SHIFT: begin
        if (pv_q) begin
          we    = 1'b1;
          waddr = pidx_q - 1'b1;
          wdata = rdata_q;
        end else if (ptr_q >= n_q) begin
          n_d     = n_q - 1'b1;
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      kind_q     <= K_ON;
      ch_q       <= '0;
      note_q     <= '0;
      vel_q      <= '0;
      freq_q     <= 1'b0;
      all_q      <= 1'b0;
      ftag_q     <= '0;
      n_q        <= '0;
      next_tag_q <= '0;
      ptr_q      <= '0;
      pv_q       <= 1'b0;
      pidx_q     <= '0;
      stop_q     <= 1'b0;
      live_q     <= '0;
      found_q    <= 1'b0;
      hit_idx_q  <= '0;
      hit_tag_q  <= '0;
      hit_ch_q   <= '0;
      hit_note_q <= '0;
      pend_q     <= 1'b0;
      pend_tag_q <= '0;
      valid_q    <= 1'b0;
      res_q      <= '0;
    end else begin
      state_q    <= state_d;
      kind_q     <= kind_d;
      ch_q       <= ch_d;
      note_q     <= note_d;
      vel_q      <= vel_d;
      freq_q     <= freq_d;
      all_q      <= all_d;
      ftag_q     <= ftag_d;
      n_q        <= n_d;
      next_tag_q <= next_tag_d;
      ptr_q      <= ptr_d;
      pv_q       <= pv_d;
      pidx_q     <= pidx_d;
      stop_q     <= stop_d;
      live_q     <= live_d;
      found_q    <= found_d;
      hit_idx_q  <= hit_idx_d;
      hit_tag_q  <= hit_tag_d;
      hit_ch_q   <= hit_ch_d;
      hit_note_q <= hit_note_d;
      pend_q     <= pend_d;
      pend_tag_q <= pend_tag_d;
      valid_q    <= valid_d;
      res_q      <= res_d;
    end
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign valid_o        = valid_q;
  assign action_o       = res_q.act;
  assign voice_tag_o    = res_q.tag;
  assign out_channel_o  = res_q.ch;
  assign out_note_o     = res_q.note;
  assign out_velocity_o = res_q.vel;
  assign forced_o       = res_q.forced;
  assign last_o         = res_q.last;

  a_beat_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> $past(state_q != ST_IDLE))
    else $error("result beat without work in progress");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= CW'(CAPACITY))
    else $error("voice count above capacity");

  a_idle_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pv_q)
    else $error("read in flight while idle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && operation_i != OP_RSVD) |=> busy_o)
    else $error("accepted item did not start work");

endmodule

@@ rtl/polyphonic_voice_allocator.sv @@
// ----------------------------------------------------------------------------
// polyphonic_voice_allocator
// Voice allocator with oldest-voice stealing and a register port.
// ----------------------------------------------------------------------------
// usage:
//   an event is taken on a rising edge with start high and busy low; busy
//   falls in the cycle that shows the last result beat, so the next event
//   can be taken at the edge that takes that beat (removal aside, see below)
//   each result beat is shown for one cycle with valid_o high, last_o marks
//   the final beat of an event; the receiver cannot stall, so beats are
//   never held back
//   voice list sits in a one-read one-write memory walked by one compare
//   unit, one entry a cycle; each event other than a reserved one scans it:
//     note-on           scan and steal if at the limit, then append
//     note-off, steal   scan; a single steal stops at the first match
//     voice finished    scan; removing an entry sends its beat when the
//                       entry is found and ends the scan, then busy stays
//                       high while the list is compacted
//   reserved operation code gives no beat and leaves busy low
//   registers max_voices (0x0) and forced_steal (0x4) are written over the
//   apb port, by the user only while the block is idle; nothing enforces it
//   reset empties the voice list, clears the tag counter and loads
//   max_voices with 8 and forced_steal with 0; no clearing pass is needed
// ----------------------------------------------------------------------------
module polyphonic_voice_allocator import pva_pkg::*; #(
  parameter int CAPACITY = 32,
  parameter int TAG_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                start,
  output logic                busy,
  input  logic [OP_W-1:0]     operation_i,
  input  logic [CH_W-1:0]     midi_channel_i,
  input  logic [NOTE_W-1:0]   midi_note_i,
  input  logic [VEL_W-1:0]    velocity_i,
  input  logic                force_req_i,
  input  logic                steal_all_i,
  input  logic [TAG_BITS-1:0] finished_tag_i,
  output logic                valid_o,
  output logic [ACT_W-1:0]    action_o,
  output logic [TAG_BITS-1:0] voice_tag_o,
  output logic [CH_W-1:0]     out_channel_o,
  output logic [NOTE_W-1:0]   out_note_o,
  output logic [VEL_W-1:0]    out_velocity_o,
  output logic                forced_o,
  output logic                last_o
);

  logic [MAXV_W-1:0] max_voices_q;
  logic              forced_steal_q;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_voices_q   <= MAXV_W'(8);
      forced_steal_q <= 1'b0;
    end else if (wr_en) begin
      case (paddr[2])
        REG_MAX_VOICES: max_voices_q   <= pwdata[MAXV_W-1:0];
        REG_FORCED:     forced_steal_q <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MAX_VOICES: prdata = 32'(max_voices_q);
      REG_FORCED:     prdata = 32'(forced_steal_q);
      default:        prdata = '0;
    endcase
  end

  pva_seq #(
    .CAPACITY(CAPACITY),
    .TAG_BITS(TAG_BITS)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .operation_i    (operation_i),
    .midi_channel_i (midi_channel_i),
    .midi_note_i    (midi_note_i),
    .velocity_i     (velocity_i),
    .force_req_i    (force_req_i),
    .steal_all_i    (steal_all_i),
    .finished_tag_i (finished_tag_i),
    .max_voices_i   (max_voices_q),
    .forced_steal_i (forced_steal_q),
    .busy_o         (busy),
    .valid_o        (valid_o),
    .action_o       (action_o),
    .voice_tag_o    (voice_tag_o),
    .out_channel_o  (out_channel_o),
    .out_note_o     (out_note_o),
    .out_velocity_o (out_velocity_o),
    .forced_o       (forced_o),
    .last_o         (last_o)
  );

endmodule

@@ tb/pva_checker.sv @@
// ----------------------------------------------------------------------------
// pva_checker
// Watches the register port, the event port and the result port of the voice
// allocator. Keeps its own age-ordered voice list, predicts the result beats
// of every accepted event and compares them field by field, in order.
// ----------------------------------------------------------------------------
module pva_checker import pva_pkg::*; #(
  parameter int CAPACITY = 32,
  parameter int TAG_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  input  logic [31:0]         prdata,
  input  logic                pready,
  input  logic                start,
  input  logic                busy,
  input  logic [OP_W-1:0]     operation_i,
  input  logic [CH_W-1:0]     midi_channel_i,
  input  logic [NOTE_W-1:0]   midi_note_i,
  input  logic [VEL_W-1:0]    velocity_i,
  input  logic                force_req_i,
  input  logic                steal_all_i,
  input  logic [TAG_BITS-1:0] finished_tag_i,
  input  logic                valid_o,
  input  logic [ACT_W-1:0]    action_o,
  input  logic [TAG_BITS-1:0] voice_tag_o,
  input  logic [CH_W-1:0]     out_channel_o,
  input  logic [NOTE_W-1:0]   out_note_o,
  input  logic [VEL_W-1:0]    out_velocity_o,
  input  logic                forced_o,
  input  logic                last_o,
  output int                  errors_o,
  output int                  pending_o
);

  typedef struct packed {
    logic [ACT_W-1:0]    action;
    logic [TAG_BITS-1:0] tag;
    logic [CH_W-1:0]     channel;
    logic [NOTE_W-1:0]   note;
    logic [VEL_W-1:0]    velocity;
    logic                forced;
    logic                last;
  } beat_t;

  logic [TAG_BITS-1:0] voice_tag     [CAPACITY];
  logic [CH_W-1:0]     voice_channel [CAPACITY];
  logic [NOTE_W-1:0]   voice_note    [CAPACITY];
  logic                voice_stolen  [CAPACITY];
  int                  voice_cnt;
  logic [TAG_BITS-1:0] next_tag;
  logic [MAXV_W-1:0]   max_voices;
  logic                forced_steal;

  beat_t expected_beats[$];
  int    fail_cnt = 0;

  assign errors_o = fail_cnt;

  function automatic void queue_beat(logic [ACT_W-1:0] act, logic [TAG_BITS-1:0] tag,
                                     logic [CH_W-1:0] ch, logic [NOTE_W-1:0] note,
                                     logic [VEL_W-1:0] vel, logic frc);
    beat_t b;
    b.action   = act;
    b.tag      = tag;
    b.channel  = ch;
    b.note     = note;
    b.velocity = vel;
    b.forced   = frc;
    b.last     = 1'b0;
    expected_beats.push_back(b);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      fail_cnt++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  // updates the voice list and queues the beats one event causes
  task automatic predict_voice_event(logic [OP_W-1:0] op, logic [CH_W-1:0] ch,
                                     logic [NOTE_W-1:0] note, logic [VEL_W-1:0] vel,
                                     logic frc, logic every, logic [TAG_BITS-1:0] ftag);
    int    first_n;
    int    live;
    int    hit;
    int    taken;
    int    i;
    beat_t b;
    first_n = expected_beats.size();
    hit     = -1;
    taken   = 0;
    live    = 0;
    case (op)
      OP_NOTE: begin
        if (vel != 0) begin
          if (max_voices != 0) begin
            for (i = 0; i < voice_cnt; i++)
              if (!voice_stolen[i]) live++;
            if (live >= max_voices) begin
              for (i = voice_cnt - 1; i >= 0; i--)
                if (!voice_stolen[i]) hit = i;
              if (hit >= 0) begin
                voice_stolen[hit] = 1'b1;
                queue_beat(ACT_STEAL, voice_tag[hit], voice_channel[hit], voice_note[hit],
                           '0, forced_steal);
              end
            end
          end
          if (voice_cnt >= CAPACITY) begin
            queue_beat(ACT_FULL, '0, ch, note, vel, 1'b0);
          end else begin
            voice_tag[voice_cnt]     = next_tag;
            voice_channel[voice_cnt] = ch;
            voice_note[voice_cnt]    = note;
            voice_stolen[voice_cnt]  = 1'b0;
            queue_beat(ACT_START, next_tag, ch, note, vel, 1'b0);
            voice_cnt++;
            next_tag++;
          end
        end else begin
          // newest matching voice wins
          for (i = 0; i < voice_cnt; i++)
            if (!voice_stolen[i] && voice_channel[i] == ch && voice_note[i] == note) hit = i;
          if (hit >= 0) queue_beat(ACT_RELEASE, voice_tag[hit], ch, note, '0, 1'b0);
          else queue_beat(ACT_NO_MATCH, '0, ch, note, '0, 1'b0);
        end
      end
      OP_STEAL: begin
        for (i = 0; i < voice_cnt; i++) begin
          if (!voice_stolen[i] && voice_channel[i] == ch && voice_note[i] == note &&
              (every || taken == 0)) begin
            voice_stolen[i] = 1'b1;
            queue_beat(ACT_STEAL, voice_tag[i], ch, note, '0, frc);
            taken++;
          end
        end
        if (taken == 0) queue_beat(ACT_NO_MATCH, '0, ch, note, '0, 1'b0);
      end
      OP_FINISH: begin
        for (i = voice_cnt - 1; i >= 0; i--)
          if (voice_tag[i] == ftag) hit = i;
        if (hit >= 0) begin
          queue_beat(ACT_REMOVED, voice_tag[hit], voice_channel[hit], voice_note[hit],
                     '0, 1'b0);
          for (i = hit; i < voice_cnt - 1; i++) begin
            voice_tag[i]     = voice_tag[i+1];
            voice_channel[i] = voice_channel[i+1];
            voice_note[i]    = voice_note[i+1];
            voice_stolen[i]  = voice_stolen[i+1];
          end
          voice_cnt--;
        end else begin
          queue_beat(ACT_NO_MATCH, ftag, '0, '0, '0, 1'b0);
        end
      end
      default: ;
    endcase
    if (expected_beats.size() > first_n) begin
      b = expected_beats.pop_back();
      b.last = 1'b1;
      expected_beats.push_back(b);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    beat_t want;
    if (!rst_ni) begin
      expected_beats.delete();
      voice_cnt    = 0;
      next_tag     = '0;
      max_voices   = 6'd8;
      forced_steal = 1'b0;
      pending_o    = 0;
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr[2])
            REG_MAX_VOICES: max_voices   = pwdata[MAXV_W-1:0];
            REG_FORCED:     forced_steal = pwdata[0];
            default: ;
          endcase
        end else begin
          case (paddr[2])
            REG_MAX_VOICES: check_field("prdata", {26'd0, max_voices}, prdata);
            REG_FORCED:     check_field("prdata", {31'd0, forced_steal}, prdata);
            default: ;
          endcase
        end
      end
      // a beat leaving at this edge belongs to an event taken earlier
      if (valid_o) begin
        if (expected_beats.size() == 0) begin
          fail_cnt++;
          $error("result beat with no expectation: action %0d tag %0d", action_o,
                 voice_tag_o);
        end else begin
          want = expected_beats.pop_front();
          check_field("action", want.action, action_o);
          check_field("voice_tag", want.tag, voice_tag_o);
          check_field("out_channel", want.channel, out_channel_o);
          check_field("out_note", want.note, out_note_o);
          check_field("out_velocity", want.velocity, out_velocity_o);
          check_field("forced", want.forced, forced_o);
          check_field("last", want.last, last_o);
        end
      end
      if (start && !busy)
        predict_voice_event(operation_i, midi_channel_i, midi_note_i, velocity_i,
                            force_req_i, steal_all_i, finished_tag_i);
      pending_o = expected_beats.size();
    end
  end

endmodule

@@ tb/tb_polyphonic_voice_allocator.sv @@
// ----------------------------------------------------------------------------
// tb_polyphonic_voice_allocator
// Drives the voice allocator: a short directed run, then random phases under
// several register settings with random sender gaps. The checker predicts
// and compares every result beat.
// ----------------------------------------------------------------------------
module tb_polyphonic_voice_allocator;
  import pva_pkg::*;

  localparam int CAPACITY    = 32;
  localparam int TAG_W       = 16;
  localparam int SETTLE      = 80;
  localparam int STALL_LIMIT = 3000;
  localparam int PHASE_BEATS = 65;

  logic                clk_i   = 1'b0;
  logic                rst_ni  = 1'b0;
  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [2:0]          paddr   = '0;
  logic [31:0]         pwdata  = '0;
  logic [31:0]         prdata;
  logic                pready;
  logic                start   = 1'b0;
  logic                busy;
  logic [OP_W-1:0]     operation_i    = OP_NOTE;
  logic [CH_W-1:0]     midi_channel_i = '0;
  logic [NOTE_W-1:0]   midi_note_i    = '0;
  logic [VEL_W-1:0]    velocity_i     = '0;
  logic                force_req_i    = 1'b0;
  logic                steal_all_i    = 1'b0;
  logic [TAG_W-1:0]    finished_tag_i = '0;
  logic                valid_o;
  logic [ACT_W-1:0]    action_o;
  logic [TAG_W-1:0]    voice_tag_o;
  logic [CH_W-1:0]     out_channel_o;
  logic [NOTE_W-1:0]   out_note_o;
  logic [VEL_W-1:0]    out_velocity_o;
  logic                forced_o;
  logic                last_o;

  int               mismatches;
  int               pending;
  int               stall_cycles = 0;
  logic [TAG_W-1:0] started_tags[$];

  always #6 clk_i = ~clk_i;

  polyphonic_voice_allocator #(
    .CAPACITY(CAPACITY),
    .TAG_BITS(TAG_W)
  ) dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .busy(busy),
    .operation_i(operation_i), .midi_channel_i(midi_channel_i),
    .midi_note_i(midi_note_i), .velocity_i(velocity_i),
    .force_req_i(force_req_i), .steal_all_i(steal_all_i),
    .finished_tag_i(finished_tag_i),
    .valid_o(valid_o), .action_o(action_o), .voice_tag_o(voice_tag_o),
    .out_channel_o(out_channel_o), .out_note_o(out_note_o),
    .out_velocity_o(out_velocity_o), .forced_o(forced_o), .last_o(last_o)
  );

  pva_checker #(
    .CAPACITY(CAPACITY),
    .TAG_BITS(TAG_W)
  ) u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .busy(busy),
    .operation_i(operation_i), .midi_channel_i(midi_channel_i),
    .midi_note_i(midi_note_i), .velocity_i(velocity_i),
    .force_req_i(force_req_i), .steal_all_i(steal_all_i),
    .finished_tag_i(finished_tag_i),
    .valid_o(valid_o), .action_o(action_o), .voice_tag_o(voice_tag_o),
    .out_channel_o(out_channel_o), .out_note_o(out_note_o),
    .out_velocity_o(out_velocity_o), .forced_o(forced_o), .last_o(last_o),
    .errors_o(mismatches), .pending_o(pending)
  );

  // tags of started voices, so that finish events mostly hit
  always @(negedge clk_i) begin
    if (valid_o && action_o == ACT_START) begin
      started_tags.push_back(voice_tag_o);
      if (started_tags.size() > 48) started_tags.pop_front();
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || valid_o || (psel && penable)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_polyphonic_voice_allocator failed");
      $finish;
    end
  end

  task automatic drive_event(input logic [OP_W-1:0] op, input logic [CH_W-1:0] ch,
                             input logic [NOTE_W-1:0] note, input logic [VEL_W-1:0] vel,
                             input logic frc, input logic every,
                             input logic [TAG_W-1:0] ftag, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start          <= 1'b1;
    operation_i    <= op;
    midi_channel_i <= ch;
    midi_note_i    <= note;
    velocity_i     <= vel;
    force_req_i    <= frc;
    steal_all_i    <= every;
    finished_tag_i <= ftag;
    do @(posedge clk_i); while (busy);
  endtask

  // hold off until every expected beat is out and the block is quiet
  task automatic drain_results();
    start <= 1'b0;
    do @(negedge clk_i); while (pending != 0 || busy);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_event(input int on_pct, input int gap, output logic counted);
    logic [OP_W-1:0]   op;
    logic [CH_W-1:0]   ch;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  vel;
    logic [TAG_W-1:0]  ftag;
    int                pick;
    ch   = CH_W'($urandom_range(0, 1));
    note = NOTE_W'(60 + $urandom_range(0, 3));
    if ($urandom_range(0, 4) == 0) begin
      ch   = CH_W'($urandom);
      note = NOTE_W'($urandom);
    end
    vel  = VEL_W'($urandom_range(1, 127));
    ftag = TAG_W'($urandom);
    op   = OP_NOTE;
    if ($urandom_range(0, 99) >= on_pct) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) vel = '0;
      else if (pick < 55) op = OP_STEAL;
      else if (pick < 95) op = OP_FINISH;
      else op = OP_RSVD;
      if (op == OP_FINISH && started_tags.size() > 0 && $urandom_range(0, 3) != 0)
        ftag = started_tags[$urandom_range(0, started_tags.size() - 1)];
    end
    drive_event(op, ch, note, vel, 1'($urandom), 1'($urandom), ftag, gap);
    counted = (op != OP_RSVD);
  endtask

  task automatic run_phase(input logic [5:0] maxv, input logic frc, input int on_pct);
    int   done;
    int   gap;
    logic calm;
    logic counted;
    drain_results();
    apb_access(1'b1, REG_MAX_VOICES, {26'd0, maxv});
    apb_access(1'b1, REG_FORCED, {31'd0, frc});
    apb_access(1'b0, REG_MAX_VOICES, '0);
    apb_access(1'b0, REG_FORCED, '0);
    done = 0;
    calm = 1'b0;
    while (done < PHASE_BEATS) begin
      if (done % 16 == 0) calm = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 39) == 0) drain_results();
      gap = calm ? 0 : $urandom_range(0, 3);
      random_event(on_pct, gap, counted);
      if (counted) done++;
    end
  endtask

  initial begin : stimulus
    int t;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    apb_access(1'b0, REG_MAX_VOICES, '0);
    apb_access(1'b0, REG_FORCED, '0);

    // directed
    drive_event(OP_NOTE, 4'd0, 7'd0, 7'd127, 1'b0, 1'b0, '0, 0);
    drive_event(OP_NOTE, 4'd15, 7'd127, 7'd1, 1'b0, 1'b0, '0, 2);
    drive_event(OP_NOTE, 4'd15, 7'd127, 7'd0, 1'b0, 1'b0, '0, 0);
    drive_event(OP_NOTE, 4'd3, 7'd5, 7'd0, 1'b1, 1'b1, 16'hFFFF, 1);
    drive_event(OP_STEAL, 4'd0, 7'd0, 7'd0, 1'b1, 1'b0, '0, 0);
    // stolen voice no longer answers a note-off
    drive_event(OP_NOTE, 4'd0, 7'd0, 7'd0, 1'b0, 1'b0, '0, 3);
    drive_event(OP_NOTE, 4'd0, 7'd0, 7'd64, 1'b0, 1'b0, '0, 0);
    drive_event(OP_NOTE, 4'd0, 7'd0, 7'd85, 1'b0, 1'b0, '0, 0);
    drive_event(OP_STEAL, 4'd0, 7'd0, 7'd0, 1'b0, 1'b1, '0, 1);
    drive_event(OP_STEAL, 4'd7, 7'd70, 7'd0, 1'b1, 1'b1, '0, 0);
    drive_event(OP_FINISH, 4'd0, 7'd0, 7'd0, 1'b0, 1'b0, 16'd2, 0);
    drive_event(OP_FINISH, 4'd0, 7'd0, 7'd0, 1'b0, 1'b0, 16'hFFFF, 2);
    drive_event(OP_FINISH, 4'd0, 7'd0, 7'd0, 1'b0, 1'b0, 16'd0, 0);
    drive_event(OP_RSVD, 4'd15, 7'd127, 7'd127, 1'b1, 1'b1, 16'hFFFF, 0);
    // live voices reach the default limit of eight, the last two note-ons steal
    for (t = 0; t < 9; t++)
      drive_event(OP_NOTE, 4'd2, 7'(40 + t), 7'(10 * t + 1), 1'b0, 1'b0, '0, t % 3);

    run_phase(6'd0, 1'b0, 60);
    run_phase(6'd1, 1'b1, 45);
    run_phase(6'd32, 1'b0, 65);
    run_phase(6'd2, 1'b1, 40);
    run_phase(6'($urandom_range(0, 32)), 1'($urandom), 45);
    run_phase(6'd8, 1'b0, 45);

    drain_results();
    if (mismatches == 0 && pending == 0) begin
      $display("tb_polyphonic_voice_allocator passed");
    end else begin
      $display("tb_polyphonic_voice_allocator failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/pva_pkg.sv
rtl/pva_cmp.sv
rtl/pva_seq.sv
rtl/polyphonic_voice_allocator.sv
tb/pva_checker.sv
tb/tb_polyphonic_voice_allocator.sv
